>>> sv/h2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

	localparam int FRAC_BITS_DEF = 20;

	localparam int PCT_MAX      = 100;
	localparam int HUE_WRAP     = 360;
	localparam int SCALE8       = 255;

	// floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT for n below 43000
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	// floor(n / 360) = (n * DIV360_MUL) >> DIV360_SHIFT for n below 380000
	localparam int DIV360_MUL   = 186414;
	localparam int DIV360_SHIFT = 26;
	localparam int SCALE8_MUL   = SCALE8 * DIV100_MUL;

	localparam int THIRD_NUM    = 33333;
	localparam int TWO3_NUM     = 66666;
	localparam int CONST_DEN    = 100000;

	typedef struct packed {
		logic [8:0] hue_degrees;
		logic [6:0] saturation_pct;
		logic [6:0] lightness_pct;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_word_t;

	typedef struct packed {
		logic       gray;
		logic [6:0] pct;
	} side_t;

	typedef enum logic [1:0] {
		RG_RISE,
		RG_HIGH,
		RG_FALL,
		RG_LOW
	} region_t;

endpackage

`default_nettype wire

>>> sv/h2r_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_norm #(
	parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  h2r_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output h2r_pkg::side_t       side,
	output logic [FRAC_BITS:0]   l_fx,
	output logic [FRAC_BITS:0]   s_fx,
	output logic [FRAC_BITS:0]   h_fx
);
	import h2r_pkg::*;

	localparam int WF = FRAC_BITS + 1;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [WF-1:0] R100   = WF'(ONE_L / PCT_MAX);
	localparam logic [13:0]   REM100 = 14'(ONE_L % PCT_MAX);
	localparam logic [WF-1:0] R360   = WF'(ONE_L / HUE_WRAP);
	localparam logic [16:0]   REM360 = 17'(ONE_L % HUE_WRAP);

	logic          rdy1, rdy2;
	logic          v_s1, v_s2;
	side_t         side_s1, side_s2;
	logic [WF-1:0] lb_s1, sb_s1, hb_s1;
	logic [13:0]   lr_s1, sr_s1;
	logic [16:0]   hr_s1;
	logic [WF-1:0] l_s2, s_s2, h_s2;

	logic [8:0]    h_w;
	logic [6:0]    s_c, l_c;
	logic [26:0]   lq, sq;
	logic [34:0]   hq;

	assign rdy1     = !v_s1 || rdy2;
	assign rdy2     = !v_s2 || out_ready;
	assign in_ready = rdy1;

	// range fixes on the raw word
	always_comb begin
		h_w = (in_word.hue_degrees >= 9'(HUE_WRAP)) ?
			in_word.hue_degrees - 9'(HUE_WRAP) : in_word.hue_degrees;
		s_c = (in_word.saturation_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : in_word.saturation_pct;
		l_c = (in_word.lightness_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : in_word.lightness_pct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// x * ONE / d split as x * (ONE / d) + x * (ONE % d) / d
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			side_s1.gray <= (s_c == 7'd0);
			side_s1.pct  <= l_c;
			lb_s1        <= WF'(WF'(l_c) * R100);
			sb_s1        <= WF'(WF'(s_c) * R100);
			hb_s1        <= WF'(WF'(h_w) * R360);
			lr_s1        <= 14'(14'(l_c) * REM100);
			sr_s1        <= 14'(14'(s_c) * REM100);
			hr_s1        <= 17'(17'(h_w) * REM360);
		end
	end

	always_comb begin
		lq = 27'(lr_s1) * 27'(DIV100_MUL);
		sq = 27'(sr_s1) * 27'(DIV100_MUL);
		hq = 35'(hr_s1) * 35'(DIV360_MUL);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			side_s2 <= side_s1;
			l_s2    <= lb_s1 + WF'(lq >> DIV100_SHIFT);
			s_s2    <= sb_s1 + WF'(sq >> DIV100_SHIFT);
			h_s2    <= hb_s1 + WF'(hq >> DIV360_SHIFT);
		end
	end

	assign out_valid = v_s2;
	assign side      = side_s2;
	assign l_fx      = l_s2;
	assign s_fx      = s_s2;
	assign h_fx      = h_s2;

endmodule

`default_nettype wire

>>> sv/h2r_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_blend #(
	parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  h2r_pkg::side_t                side_in,
	input  logic [FRAC_BITS:0]            l_fx,
	input  logic [FRAC_BITS:0]            s_fx,
	input  logic [FRAC_BITS:0]            h_fx,
	output logic                          out_valid,
	input  logic                          out_ready,
	output h2r_pkg::side_t                side_out,
	output logic signed [FRAC_BITS+2:0]   lo,
	output logic [FRAC_BITS:0]            hi,
	output logic [FRAC_BITS:0]            diff,
	output h2r_pkg::region_t [2:0]        rg,
	output logic [2:0]                    neg,
	output logic [2:0][FRAC_BITS:0]       mag
);
	import h2r_pkg::*;

	localparam int WF = FRAC_BITS + 1;
	localparam int WS = FRAC_BITS + 3;
	localparam int WT = FRAC_BITS + 4;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [WF-1:0] ONE_W = WF'(ONE_L);
	localparam logic [WF-1:0] HALF  = WF'(ONE_L >> 1);
	localparam logic [WF-1:0] THIRD =
		WF'(((longint'(THIRD_NUM) << FRAC_BITS) + longint'(CONST_DEN / 2)) / CONST_DEN);
	localparam logic [WF-1:0] TWO3 =
		WF'(((longint'(TWO3_NUM) << FRAC_BITS) + longint'(CONST_DEN / 2)) / CONST_DEN);

	logic                   rdy3, rdy4;
	logic                   v_s3, v_s4;
	side_t                  side_s3, side_s4;
	logic [WF-1:0]          hi_s3, l_s3;
	logic [2:0][WF-1:0]     t_s3;
	logic signed [WS-1:0]   lo_s4;
	logic [WF-1:0]          hi_s4, diff_s4;
	region_t [2:0]          rg_s4;
	logic [2:0]             neg_s4;
	logic [2:0][WF-1:0]     mag_s4;

	logic [2*WF-1:0]        ls_p;
	logic [WF-1:0]          fx;
	logic [WF:0]            hi_c;
	logic [WF-1:0]          tr_sum, t_r, t_b;

	logic signed [WS-1:0]   lo_c, diff_c;
	logic [WF-1:0]          diff_n;
	logic [WT-1:0]          t6, t3;
	logic signed [WT-1:0]   f, f6;
	region_t [2:0]          rg_n;
	logic [2:0]             neg_n;
	logic [2:0][WF-1:0]     mag_n;

	assign rdy3     = !v_s3 || rdy4;
	assign rdy4     = !v_s4 || out_ready;
	assign in_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= in_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// upper level and the three channel hues
	always_comb begin
		ls_p = (2*WF)'(l_fx) * (2*WF)'(s_fx);
		fx   = WF'(ls_p >> FRAC_BITS);
		if (l_fx < HALF) begin
			hi_c = (WF+1)'(l_fx) + (WF+1)'(fx);
		end else begin
			hi_c = (WF+1)'(l_fx) + (WF+1)'(s_fx) - (WF+1)'(fx);
		end
		tr_sum = h_fx + THIRD;
		t_r    = (tr_sum > ONE_W) ? tr_sum - ONE_W : tr_sum;
		t_b    = (h_fx < THIRD) ? h_fx + ONE_W - THIRD : h_fx - THIRD;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_valid) begin
			side_s3 <= side_in;
			hi_s3   <= WF'(hi_c);
			l_s3    <= l_fx;
			t_s3[0] <= t_r;
			t_s3[1] <= h_fx;
			t_s3[2] <= t_b;
		end
	end

	// lower level, spread and per-channel segment with its slope factor
	always_comb begin
		lo_c   = $signed(WS'({l_s3, 1'b0})) - $signed(WS'(hi_s3));
		diff_c = $signed(WS'(hi_s3)) - lo_c;
		diff_n = diff_c[WS-1] ? '0 : WF'(diff_c);
		t6     = '0;
		t3     = '0;
		f      = '0;
		f6     = '0;
		for (int i = 0; i < 3; i++) begin
			t6       = WT'(t_s3[i]) * WT'(6);
			t3       = WT'(t_s3[i]) * WT'(3);
			f        = $signed(WT'(TWO3)) - $signed(WT'(t_s3[i]));
			f6       = f * $signed(WT'(6));
			rg_n[i]  = RG_LOW;
			neg_n[i] = 1'b0;
			mag_n[i] = '0;
			if (t6 < WT'(ONE_L)) begin
				rg_n[i]  = RG_RISE;
				mag_n[i] = WF'(t6);
			end else if (t_s3[i] < HALF) begin
				rg_n[i]  = RG_HIGH;
			end else if (t3 < WT'(2 * ONE_L)) begin
				rg_n[i]  = RG_FALL;
				neg_n[i] = f6[WT-1];
				mag_n[i] = f6[WT-1] ? WF'(-f6) : WF'(f6);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			side_s4 <= side_s3;
			lo_s4   <= lo_c;
			hi_s4   <= hi_s3;
			diff_s4 <= diff_n;
			rg_s4   <= rg_n;
			neg_s4  <= neg_n;
			mag_s4  <= mag_n;
		end
	end

	assign out_valid = v_s4;
	assign side_out  = side_s4;
	assign lo        = lo_s4;
	assign hi        = hi_s4;
	assign diff      = diff_s4;
	assign rg        = rg_s4;
	assign neg       = neg_s4;
	assign mag       = mag_s4;

endmodule

`default_nettype wire

>>> sv/h2r_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_chan #(
	parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  h2r_pkg::side_t                side_in,
	input  logic signed [FRAC_BITS+2:0]   lo,
	input  logic [FRAC_BITS:0]            hi,
	input  logic [FRAC_BITS:0]            diff,
	input  h2r_pkg::region_t [2:0]        rg,
	input  logic [2:0]                    neg,
	input  logic [2:0][FRAC_BITS:0]       mag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output h2r_pkg::out_word_t            out_word
);
	import h2r_pkg::*;

	localparam int WF = FRAC_BITS + 1;
	localparam int WS = FRAC_BITS + 3;
	localparam int WV = WS + 1;
	localparam int WP = WV + 7;

	logic                   rdy5, rdy6, rdy7, rdy8;
	logic                   v_s5, v_s6, v_s7, v_s8;
	side_t                  side_s5, side_s6;
	logic signed [WS-1:0]   lo_s5;
	logic [WF-1:0]          hi_s5;
	region_t [2:0]          rg_s5;
	logic [2:0]             neg_s5;
	logic [2:0][WF-1:0]     m_s5;
	logic signed [WV-1:0]   lvl_s6 [3];
	logic [2:0][6:0]        pct_s7;
	logic [2:0][7:0]        rgb_s8;

	logic [2*WF-1:0]        prod [3];
	logic signed [WV-1:0]   v_n [3];
	logic [WP-1:0]          pu [3];
	logic [2:0][6:0]        pct_n;
	logic [27:0]            sq [3];

	assign rdy5     = !v_s5 || rdy6;
	assign rdy6     = !v_s6 || rdy7;
	assign rdy7     = !v_s7 || rdy8;
	assign rdy8     = !v_s8 || out_ready;
	assign in_ready = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy5) begin
				v_s5 <= in_valid;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
			if (rdy7) begin
				v_s7 <= v_s6;
			end
			if (rdy8) begin
				v_s8 <= v_s7;
			end
		end
	end

	// slope product, truncated magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = (2*WF)'(diff) * (2*WF)'(mag[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			side_s5 <= side_in;
			lo_s5   <= lo;
			hi_s5   <= hi;
			rg_s5   <= rg;
			neg_s5  <= neg;
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= WF'(prod[i] >> FRAC_BITS);
			end
		end
	end

	// channel level
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (rg_s5[i])
				RG_RISE: v_n[i] = WV'(lo_s5) + $signed(WV'(m_s5[i]));
				RG_HIGH: v_n[i] = $signed(WV'(hi_s5));
				RG_FALL: begin
					if (neg_s5[i]) begin
						v_n[i] = WV'(lo_s5) - $signed(WV'(m_s5[i]));
					end else begin
						v_n[i] = WV'(lo_s5) + $signed(WV'(m_s5[i]));
					end
				end
				RG_LOW:  v_n[i] = WV'(lo_s5);
				default: v_n[i] = WV'(lo_s5);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			side_s6 <= side_s5;
			for (int i = 0; i < 3; i++) begin
				lvl_s6[i] <= v_n[i];
			end
		end
	end

	// whole percent, clamped; gray words take the lightness directly
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pu[i] = (WP'($unsigned(lvl_s6[i])) * WP'(PCT_MAX)) >> FRAC_BITS;
			if (side_s6.gray) begin
				pct_n[i] = side_s6.pct;
			end else if (lvl_s6[i] <= 0) begin
				pct_n[i] = 7'd0;
			end else if (pu[i] > WP'(PCT_MAX)) begin
				pct_n[i] = 7'(PCT_MAX);
			end else begin
				pct_n[i] = 7'(pu[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy7 && v_s6) begin
			pct_s7 <= pct_n;
		end
	end

	// pct * 255 / 100
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq[i] = 28'(pct_s7[i]) * 28'(SCALE8_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy8 && v_s7) begin
			for (int i = 0; i < 3; i++) begin
				rgb_s8[i] <= 8'(sq[i] >> DIV100_SHIFT);
			end
		end
	end

	assign out_valid      = v_s8;
	assign out_word.red   = rgb_s8[0];
	assign out_word.green = rgb_s8[1];
	assign out_word.blue  = rgb_s8[2];

endmodule

`default_nettype wire

>>> sv/hsl_to_rgb.sv
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB converter: takes hue in degrees with saturation and lightness in
// percent and returns 8-bit red, green and blue, one word per clock while the output
// is not stalled. The datapath is an eight-stage pipeline in fixed point with
// FRAC_BITS fraction bits, and a word is registered in each stage in turn before
// it appears on rgb. Each stage has its own valid bit and holds only while the
// stage after it is full and held, so bubbles close up and a stall at the output
// drops or repeats nothing; hsl_ready falls only when all eight stages are full
// and the output word is not being taken.
module hsl_to_rgb #(
	parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hsl_valid,
	output logic                 hsl_ready,
	input  h2r_pkg::in_word_t    hsl,
	output logic                 rgb_valid,
	input  logic                 rgb_ready,
	output h2r_pkg::out_word_t   rgb
);
	import h2r_pkg::*;

	logic                          n_valid, n_ready;
	side_t                         n_side;
	logic [FRAC_BITS:0]            n_l, n_s, n_h;

	logic                          b_valid, b_ready;
	side_t                         b_side;
	logic signed [FRAC_BITS+2:0]   b_lo;
	logic [FRAC_BITS:0]            b_hi, b_diff;
	region_t [2:0]                 b_rg;
	logic [2:0]                    b_neg;
	logic [2:0][FRAC_BITS:0]       b_mag;

	h2r_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsl_valid),
		.in_ready  (hsl_ready),
		.in_word   (hsl),
		.out_valid (n_valid),
		.out_ready (n_ready),
		.side      (n_side),
		.l_fx      (n_l),
		.s_fx      (n_s),
		.h_fx      (n_h)
	);

	h2r_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n_valid),
		.in_ready  (n_ready),
		.side_in   (n_side),
		.l_fx      (n_l),
		.s_fx      (n_s),
		.h_fx      (n_h),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.side_out  (b_side),
		.lo        (b_lo),
		.hi        (b_hi),
		.diff      (b_diff),
		.rg        (b_rg),
		.neg       (b_neg),
		.mag       (b_mag)
	);

	h2r_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.side_in   (b_side),
		.lo        (b_lo),
		.hi        (b_hi),
		.diff      (b_diff),
		.rg        (b_rg),
		.neg       (b_neg),
		.mag       (b_mag),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.out_word  (rgb)
	);

endmodule

`default_nettype wire

>>> sv/h2r_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 hsl_valid,
	input logic                 hsl_ready,
	input h2r_pkg::in_word_t    hsl,
	input logic                 rgb_valid,
	input logic                 rgb_ready,
	input h2r_pkg::out_word_t   rgb
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
		else $error("output word changed while stalled");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_ready |-> rgb_valid && !rgb_ready)
		else $error("input stalled without output backpressure");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rgb_valid)
		else $error("output valid right after reset");

	a_black_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && hsl_ready && hsl.lightness_pct == 7'd0 && rgb_ready)
		##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
		##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
		|=> rgb_valid && rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0)
		else $error("black word not delivered after eight free cycles");

endmodule

bind hsl_to_rgb h2r_checker u_h2r_checker (.*);

`default_nettype wire
